@@ hdl/ctdt_pkg.sv @@
`timescale 1ns / 1ps

package ctdt_pkg;

	localparam int COUNT_W = 13;
	localparam int DEB_W   = 10;
	localparam int TS_W    = 32;
	localparam int MODE_W  = 3;
	localparam int MIN_W   = 7;
	localparam int SEC_W   = 6;
	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 2;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 13;

	localparam logic [COUNT_W-1:0] START_RST = 13'd300;
	localparam logic [COUNT_W-1:0] START_MAX = 13'd5999;
	localparam logic [DEB_W-1:0]   DEB_RST   = 10'd50;

	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ARMED    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ACTIVE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEFUSED  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EXPLODED = 3'd4;

	localparam logic [KIND_W-1:0] KIND_DASHES = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MMSS   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ZEROS  = 2'd2;

	localparam logic [CIDX_W-1:0] REG_START_SECONDS = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DEBOUNCE_MS   = 2'd1;

	// 2^20 / 60 rounded up; exact for counts below 6000
	localparam logic [14:0] RECIP60 = 15'd17477;
	localparam int          RECIP_SH = 20;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [TS_W-1:0]    now_ms;
		logic               start_level;
		logic               reset_level;
		logic [MODE_W-1:0]  new_mode;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] remaining;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic               running;
		logic               expired;
		logic [MODE_W-1:0]  mode;
		logic [KIND_W-1:0]  display_kind;
		logic               colon_on;
		logic               flash;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] start_seconds;
		logic [DEB_W-1:0]   debounce_ms;
	} cfg_t;

	function automatic logic [MIN_W-1:0] div60(input logic [COUNT_W-1:0] v);
		logic [COUNT_W+14:0] p;
		p = v * RECIP60;
		return p[RECIP_SH +: MIN_W];
	endfunction

endpackage

@@ hdl/ctdt_if.sv @@
`timescale 1ns / 1ps

interface ctdt_item_if;
	import ctdt_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [TS_W-1:0]   now_ms;
	logic              start_level;
	logic              reset_level;
	logic [MODE_W-1:0] new_mode;

	modport source (output valid, func, now_ms, start_level, reset_level, new_mode,
		input ready);
	modport sink (input valid, func, now_ms, start_level, reset_level, new_mode,
		output ready);
endinterface

interface ctdt_result_if;
	import ctdt_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] remaining;
	logic [MIN_W-1:0]   minutes;
	logic [SEC_W-1:0]   seconds;
	logic               running;
	logic               expired;
	logic [MODE_W-1:0]  mode;
	logic [KIND_W-1:0]  display_kind;
	logic               colon_on;
	logic               flash;

	modport source (output valid, remaining, minutes, seconds, running, expired, mode,
		display_kind, colon_on, flash, input ready);
	modport sink (input valid, remaining, minutes, seconds, running, expired, mode,
		display_kind, colon_on, flash, output ready);
endinterface

interface ctdt_cfg_if;
	import ctdt_pkg::*;
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/countdown_timer_with_buttons_core.sv @@
`timescale 1ns / 1ps
// Each accepted item passes the input register, then the result register, to the output.
// One item per cycle unless result.ready stalls; the timer state updates in one pass per item.
// A waiting result does not block the next item while the result register can drain.
// Reset (arst_n low, asynchronous): idle mode, count 300, debounce 50 ms, flags and
// press timestamps cleared, both pipeline stages empty.

module countdown_timer_with_buttons_core (
	input  logic              clk,
	input  logic              arst_n,
	ctdt_item_if.sink         item,
	ctdt_result_if.source     result,
	ctdt_cfg_if.sink          cfg
);
	import ctdt_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    fire;
	cfg_t    cfg_regs;

	assign advance    = !valid_s2 || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.func        <= item.func;
			item_s1.now_ms      <= item.now_ms;
			item_s1.start_level <= item.start_level;
			item_s1.reset_level <= item.reset_level;
			item_s1.new_mode    <= item.new_mode;
		end
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	ctdt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	ctdt_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_regs),
		.res    (res_comb)
	);

	assign result.valid        = valid_s2;
	assign result.remaining    = res_s2.remaining;
	assign result.minutes      = res_s2.minutes;
	assign result.seconds      = res_s2.seconds;
	assign result.running      = res_s2.running;
	assign result.expired      = res_s2.expired;
	assign result.mode         = res_s2.mode;
	assign result.display_kind = res_s2.display_kind;
	assign result.colon_on     = res_s2.colon_on;
	assign result.flash        = res_s2.flash;

endmodule

@@ hdl/ctdt_cfg.sv @@
`timescale 1ns / 1ps

module ctdt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ctdt_pkg::CIDX_W-1:0]   wr_index,
	input  logic [ctdt_pkg::CDATA_W-1:0]  wr_data,
	output ctdt_pkg::cfg_t                cfg
);
	import ctdt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_seconds <= START_RST;
			cfg_q.debounce_ms   <= DEB_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_SECONDS: begin
					cfg_q.start_seconds <= (wr_data[COUNT_W-1:0] > START_MAX) ?
						START_MAX : wr_data[COUNT_W-1:0];
				end
				REG_DEBOUNCE_MS: begin
					cfg_q.debounce_ms <= wr_data[DEB_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/ctdt_step.sv @@
`timescale 1ns / 1ps

module ctdt_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  ctdt_pkg::item_t  item,
	input  ctdt_pkg::cfg_t   cfg,
	output ctdt_pkg::result_t res
);
	import ctdt_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] cnt;
		logic               run;
		logic               done;
		logic [MODE_W-1:0]  mode;
		logic               blink;
		logic [TS_W-1:0]    start_last;
		logic [TS_W-1:0]    reset_last;
	} tstate_t;

	tstate_t st_q;
	tstate_t nx;
	logic [TS_W-1:0]  start_dt;
	logic [TS_W-1:0]  reset_dt;
	logic             start_hit;
	logic             reset_hit;
	logic [MIN_W-1:0] mins;
	logic [COUNT_W-1:0] mins_x60;

	assign start_dt  = item.now_ms - st_q.start_last;
	assign reset_dt  = item.now_ms - st_q.reset_last;
	assign start_hit = !item.start_level && (start_dt > {{(TS_W-DEB_W){1'b0}}, cfg.debounce_ms});
	assign reset_hit = !item.reset_level && (reset_dt > {{(TS_W-DEB_W){1'b0}}, cfg.debounce_ms});

	always_comb begin
		nx = st_q;
		case (item.func)
			FUNC_TICK: begin
				if (st_q.run && !st_q.done) begin
					if (st_q.cnt > COUNT_W'(1)) begin
						nx.cnt = st_q.cnt - 1'b1;
					end else begin
						nx.cnt  = '0;
						nx.run  = 1'b0;
						nx.done = 1'b1;
					end
					nx.blink = !st_q.blink;
				end
			end
			FUNC_POLL: begin
				if (start_hit) begin
					nx.start_last = item.now_ms;
					if (st_q.mode == MODE_IDLE || st_q.mode == MODE_ARMED) begin
						nx.mode = MODE_ACTIVE;
						nx.done = 1'b0;
						nx.run  = 1'b1;
					end
				end
				if (reset_hit) begin
					nx.reset_last = item.now_ms;
					nx.run   = 1'b0;
					nx.done  = 1'b0;
					nx.cnt   = cfg.start_seconds;
					nx.mode  = MODE_ARMED;
					nx.blink = 1'b0;
				end
			end
			FUNC_SET: begin
				if (item.new_mode <= MODE_EXPLODED) begin
					nx.mode = item.new_mode;
					if (item.new_mode == MODE_ACTIVE) begin
						nx.done = 1'b0;
						nx.run  = 1'b1;
					end else if (item.new_mode == MODE_DEFUSED ||
						item.new_mode == MODE_EXPLODED) begin
						nx.run = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.cnt        <= START_RST;
			st_q.run        <= 1'b0;
			st_q.done       <= 1'b0;
			st_q.mode       <= MODE_IDLE;
			st_q.blink      <= 1'b0;
			st_q.start_last <= '0;
			st_q.reset_last <= '0;
		end else if (fire) begin
			st_q <= nx;
		end
	end

	assign mins     = div60(nx.cnt);
	assign mins_x60 = ({{(COUNT_W-MIN_W){1'b0}}, mins} << 6)
		- ({{(COUNT_W-MIN_W){1'b0}}, mins} << 2);

	always_comb begin
		res.remaining = nx.cnt;
		res.minutes   = mins;
		res.seconds   = SEC_W'(nx.cnt - mins_x60);
		res.running   = nx.run;
		res.expired   = nx.done;
		res.mode      = nx.mode;
		if (nx.mode == MODE_IDLE) begin
			res.display_kind = KIND_DASHES;
		end else if (nx.mode == MODE_EXPLODED) begin
			res.display_kind = KIND_ZEROS;
		end else begin
			res.display_kind = KIND_MMSS;
		end
		res.colon_on = (nx.mode == MODE_ACTIVE) ? nx.blink : 1'b1;
		res.flash    = (nx.mode == MODE_ACTIVE) && nx.done;
	end

endmodule

@@ tb/countdown_checker.sv @@
`timescale 1ns / 1ps

module countdown_checker (
	input  logic   clk,
	input  logic   arst_n,
	ctdt_item_if   item,
	ctdt_result_if result,
	ctdt_cfg_if    cfg,
	output int     errors,
	output int     pending
);
	import ctdt_pkg::*;

	logic [COUNT_W-1:0] start_secs;
	logic [DEB_W-1:0]   deb_ms;
	logic [COUNT_W-1:0] count_left;
	logic               run;
	logic               done;
	logic               blink;
	logic [MODE_W-1:0]  mode_q;
	logic [TS_W-1:0]    start_last;
	logic [TS_W-1:0]    reset_last;

	result_t expected_readouts[$];
	result_t want;
	result_t got;
	item_t   it;
	int      mism;

	task automatic advance_timer(input item_t t, output result_t r);
		case (t.func)
			FUNC_TICK: begin
				if (run && !done) begin
					if (count_left != 0)
						count_left = count_left - 1'b1;
					if (count_left == 0) begin
						run  = 1'b0;
						done = 1'b1;
					end
					blink = !blink;
				end
			end
			FUNC_POLL: begin
				// start is applied before reset when both are pressed, so reset wins
				if (!t.start_level && (t.now_ms - start_last) > deb_ms) begin
					start_last = t.now_ms;
					if (mode_q == MODE_IDLE || mode_q == MODE_ARMED) begin
						mode_q = MODE_ACTIVE;
						done   = 1'b0;
						run    = 1'b1;
					end
				end
				if (!t.reset_level && (t.now_ms - reset_last) > deb_ms) begin
					reset_last = t.now_ms;
					run        = 1'b0;
					done       = 1'b0;
					count_left = start_secs;
					mode_q     = MODE_ARMED;
					blink      = 1'b0;
				end
			end
			FUNC_SET: begin
				if (t.new_mode <= MODE_EXPLODED) begin
					mode_q = t.new_mode;
					if (t.new_mode == MODE_ACTIVE) begin
						done = 1'b0;
						run  = 1'b1;
					end else if (t.new_mode == MODE_DEFUSED || t.new_mode == MODE_EXPLODED) begin
						run = 1'b0;
					end
				end
			end
			default: ;
		endcase
		r.remaining = count_left;
		r.minutes   = MIN_W'(count_left / 60);
		r.seconds   = SEC_W'(count_left % 60);
		r.running   = run;
		r.expired   = done;
		r.mode      = mode_q;
		if (mode_q == MODE_IDLE)
			r.display_kind = KIND_DASHES;
		else if (mode_q == MODE_EXPLODED)
			r.display_kind = KIND_ZEROS;
		else
			r.display_kind = KIND_MMSS;
		r.colon_on = (mode_q == MODE_ACTIVE) ? blink : 1'b1;
		r.flash    = (mode_q == MODE_ACTIVE) && done;
	endtask

	function automatic string readout_str(input result_t r);
		return $sformatf("rem=%0d mm=%0d ss=%0d run=%0b exp=%0b mode=%0d kind=%0d %s",
			r.remaining, r.minutes, r.seconds, r.running, r.expired, r.mode,
			r.display_kind, $sformatf("colon=%0b flash=%0b", r.colon_on, r.flash));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_secs = START_RST;
			deb_ms     = DEB_RST;
			count_left = START_RST;
			run        = 1'b0;
			done       = 1'b0;
			blink      = 1'b0;
			mode_q     = MODE_IDLE;
			start_last = '0;
			reset_last = '0;
			mism       = 0;
			expected_readouts.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_START_SECONDS)
					start_secs = (cfg.data > START_MAX) ? START_MAX : cfg.data;
				else if (cfg.index == REG_DEBOUNCE_MS)
					deb_ms = cfg.data[DEB_W-1:0];
			end
			// a result leaving now belongs to an item taken at an earlier edge
			if (result.valid && result.ready) begin
				got = '{result.remaining, result.minutes, result.seconds, result.running,
					result.expired, result.mode, result.display_kind, result.colon_on,
					result.flash};
				if (expected_readouts.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("%0t: unexpected result transaction: %s", $time,
							readout_str(got));
				end else begin
					want = expected_readouts.pop_front();
					if (got !== want) begin
						mism++;
						if (mism <= 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected %s", readout_str(want));
							$display("  actual   %s", readout_str(got));
						end
					end
				end
			end
			if (item.valid && item.ready) begin
				it = '{item.func, item.now_ms, item.start_level, item.reset_level, item.new_mode};
				advance_timer(it, want);
				expected_readouts.push_back(want);
			end
			errors  <= mism;
			pending <= expected_readouts.size();
		end
	end

endmodule

@@ tb/countdown_timer_with_buttons_core_tb.sv @@
`timescale 1ns / 1ps

module countdown_timer_with_buttons_core_tb;
	import ctdt_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [CIDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam int                PHASES      = 8;
	localparam int                PHASE_ITEMS = 229;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	bit   steady = 1'b0;

	ctdt_item_if   item_ch();
	ctdt_result_if result_ch();
	ctdt_cfg_if    cfg_ch();

	countdown_timer_with_buttons_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	countdown_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("countdown_timer_with_buttons_core regression: fail");
		$finish;
	end

	int res_wait = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				res_wait = steady ? 0 : $urandom_range(0, 6);
				result_ch.ready <= (res_wait == 0);
			end else if (res_wait > 0) begin
				res_wait--;
				result_ch.ready <= (res_wait == 0);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [TS_W-1:0] now,
		input logic sl, input logic rl, input logic [MODE_W-1:0] nm);
		int gap;
		if ($urandom_range(0, 39) == 0)
			steady = !steady;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.func        <= f;
		item_ch.now_ms      <= now;
		item_ch.start_level <= sl;
		item_ch.reset_level <= rl;
		item_ch.new_mode    <= nm;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic drain(input int tail);
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CDATA_W-1:0] secs, input logic [CDATA_W-1:0] deb,
		input bit stray);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_START_SECONDS;
		cfg_ch.data  <= secs;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= REG_DEBOUNCE_MS;
		cfg_ch.data  <= deb;
		do @(posedge clk); while (!cfg_ch.ready);
		if (stray) begin
			cfg_ch.index <= REG_UNUSED;
			cfg_ch.data  <= CDATA_W'($urandom());
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int                 secs_tab[PHASES];
		int                 deb_tab[PHASES];
		logic [CDATA_W-1:0] secs;
		logic [CDATA_W-1:0] deb;
		int                 deb_ms;
		logic [TS_W-1:0]    clock_ms;
		logic [TS_W-1:0]    any_now;
		logic [MODE_W-1:0]  any_mode;
		logic               any_sl;
		logic               any_rl;
		int                 sel;

		item_ch.valid       = 1'b0;
		item_ch.func        = FUNC_TICK;
		item_ch.now_ms      = '0;
		item_ch.start_level = 1'b1;
		item_ch.reset_level = 1'b1;
		item_ch.new_mode    = MODE_IDLE;
		result_ch.ready     = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_START_SECONDS;
		cfg_ch.data         = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: 300 s, 50 ms debounce
		send_item(FUNC_TICK, 32'd0, 1'b1, 1'b1, MODE_IDLE);
		send_item(FUNC_POLL, 32'd10, 1'b0, 1'b1, MODE_IDLE);
		send_item(FUNC_POLL, 32'd51, 1'b0, 1'b1, MODE_IDLE);
		send_item(FUNC_TICK, 32'd0, 1'b1, 1'b1, MODE_IDLE);
		send_item(FUNC_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd7);
		send_item(FUNC_POLL, 32'd1000, 1'b1, 1'b1, MODE_IDLE);
		send_item(FUNC_POLL, 32'd200, 1'b0, 1'b0, MODE_IDLE);
		send_item(FUNC_SET, 32'd0, 1'b1, 1'b1, 3'd7);
		send_item(FUNC_SET, 32'd0, 1'b1, 1'b1, 3'd5);
		send_item(FUNC_UNUSED, 32'hA5A5_5A5A, 1'b0, 1'b0, MODE_ACTIVE);
		send_item(FUNC_SET, 32'd0, 1'b1, 1'b1, MODE_ACTIVE);
		send_item(FUNC_TICK, 32'd0, 1'b1, 1'b1, MODE_IDLE);
		send_item(FUNC_SET, 32'd0, 1'b1, 1'b1, MODE_DEFUSED);
		send_item(FUNC_POLL, 32'd300, 1'b0, 1'b1, MODE_IDLE);
		send_item(FUNC_SET, 32'd0, 1'b1, 1'b1, MODE_EXPLODED);
		send_item(FUNC_SET, 32'd0, 1'b1, 1'b1, MODE_IDLE);
		send_item(FUNC_SET, 32'd0, 1'b1, 1'b1, MODE_ARMED);
		send_item(FUNC_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0, MODE_IDLE);
		send_item(FUNC_POLL, 32'd16, 1'b0, 1'b1, MODE_IDLE);
		send_item(FUNC_POLL, 32'd66, 1'b0, 1'b1, MODE_IDLE);
		send_item(FUNC_POLL, 32'd67, 1'b0, 1'b1, MODE_IDLE);
		send_item(FUNC_POLL, 32'd50, 1'b1, 1'b0, MODE_IDLE);

		secs_tab = '{0, 1, 5999, 8191, 7, 2, 0, 0};
		deb_tab  = '{0, 1023, 50, 0, 3, 1, 0, 0};
		for (int ph = 0; ph < PHASES; ph++) begin
			secs = CDATA_W'(secs_tab[ph]);
			deb  = CDATA_W'(deb_tab[ph]);
			if (ph == 6) begin
				secs = CDATA_W'($urandom_range(0, 20));
				deb  = CDATA_W'($urandom());
			end else if (ph == 7) begin
				secs = CDATA_W'($urandom());
				deb  = CDATA_W'($urandom_range(0, 15));
			end
			deb_ms = int'(deb[DEB_W-1:0]);
			drain(4);
			write_cfg(secs, deb, ph == 3);
			clock_ms = (ph == 4) ? 32'hFFFF_FF00 : $urandom();

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel      = $urandom_range(0, 99);
				any_now  = $urandom();
				any_mode = MODE_W'($urandom_range(0, 7));
				any_sl   = 1'($urandom_range(0, 1));
				any_rl   = 1'($urandom_range(0, 1));
				if (sel < 45) begin
					send_item(FUNC_TICK, any_now, any_sl, any_rl, any_mode);
				end else if (sel < 80) begin
					// presses spaced around the debounce window
					clock_ms += $urandom_range(0, 2 * deb_ms + 2);
					send_item(FUNC_POLL, clock_ms, $urandom_range(0, 9) >= 4,
						$urandom_range(0, 9) >= 3, any_mode);
				end else if (sel < 92) begin
					send_item(FUNC_SET, any_now, any_sl, any_rl,
						MODE_W'($urandom_range(MODE_IDLE, MODE_EXPLODED)));
				end else if (sel < 96) begin
					send_item(FUNC_SET, any_now, any_sl, any_rl, any_mode);
				end else if (sel < 98) begin
					send_item(FUNC_UNUSED, any_now, any_sl, any_rl, any_mode);
				end else begin
					send_item(FUNC_POLL, any_now, any_sl, any_rl, any_mode);
				end
			end
		end

		drain(10);
		if (errors == 0 && pending == 0)
			$display("countdown_timer_with_buttons_core regression: pass");
		else
			$display("countdown_timer_with_buttons_core regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/ctdt_pkg.sv
hdl/ctdt_if.sv
hdl/ctdt_cfg.sv
hdl/ctdt_step.sv
hdl/countdown_timer_with_buttons_core.sv
tb/countdown_checker.sv
tb/countdown_timer_with_buttons_core_tb.sv
